/* hw/rtl/bldf_pkg.sv */
package bldf_pkg;

	// Stream widths: payloads rounded up to whole bytes.
	localparam int unsigned InDataW  = 96;
	localparam int unsigned OutDataW = 72;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;

	// Mapping and detection constants.
	localparam logic [6:0]         RESERVE_FLOOR_PCT  = 7'd3;
	localparam logic [6:0]         KNEE_RAW_PCT       = 7'd50;
	localparam logic [6:0]         KNEE_SHOWN_PCT     = 7'd9;
	localparam logic [6:0]         FULL_PCT           = 7'd100;
	localparam logic [6:0]         MISSING_RAW_PCT    = 7'd1;
	localparam logic signed [15:0] MISSING_CURRENT_MA = 16'sd120;
	localparam logic signed [7:0]  CHARGING_MIN_PCT   = 8'sd1;
	localparam logic signed [7:0]  LEVEL_NONE         = -8'sd1;

	// Reciprocals for the two segment divisions (by 47 and by 50), scaled by 2^16.
	localparam logic [10:0] RECIP_LOW  = 11'd1395;
	localparam logic [10:0] RECIP_HIGH = 11'd1311;
	localparam logic [4:0]  RECIP_SHIFT = 5'd16;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_MAINS_THR   = 3'd0,
		REG_POWER_DEB   = 3'd1,
		REG_MISSING_DEB = 3'd2,
		REG_FREEZE      = 3'd3,
		REG_DROP_STEP   = 3'd4,
		REG_RISE_BAT    = 3'd5,
		REG_RISE_MAINS  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] mains_thr;
		logic [31:0]        power_deb;
		logic [31:0]        missing_deb;
		logic [31:0]        freeze;
		logic [31:0]        drop_step;
		logic [31:0]        rise_bat;
		logic [31:0]        rise_mains;
	} cfg_t;

	// Input item, last field in the lowest bits.
	typedef struct packed {
		logic               charging_now;
		logic signed [15:0] bus_voltage_mv;
		logic signed [15:0] battery_current_ma;
		logic [14:0]        battery_voltage_mv;
		logic signed [8:0]  gauge_pct;
		logic [31:0]        now_ms;
	} sample_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic               charging_out;
		logic               has_bus;
		logic signed [15:0] bus_out_mv;
		logic signed [15:0] current_out_ma;
		logic [14:0]        voltage_out_mv;
		logic signed [7:0]  gauge_out_pct;
		logic signed [7:0]  disp_pct;
		logic               disp_valid;
		logic               batt_absent;
		logic               mains_on;
	} result_t;

	// Power tracker status as seen after the current sample.
	typedef struct packed {
		logic mains_on;
		logic batt_absent;
		logic frozen;
	} pwr_status_t;

	// Piecewise-linear map of the shown level, each segment rounded to nearest.
	function automatic logic [6:0] map_usable(input logic [6:0] r);
		logic [8:0]  n_lo;
		logic [12:0] n_hi;
		logic [19:0] p_lo;
		logic [23:0] p_hi;
		logic [6:0]  res;
		n_lo = 9'(({2'b0, r} - 9'(RESERVE_FLOOR_PCT)) * 9'd9) + 9'd23;
		n_hi = 13'(({6'b0, r} - 13'(KNEE_RAW_PCT)) * 13'd91) + 13'd25;
		p_lo = 20'(n_lo) * 20'(RECIP_LOW);
		p_hi = 24'(n_hi) * 24'(RECIP_HIGH);
		if (r <= RESERVE_FLOOR_PCT) begin
			res = 7'd0;
		end else if (r >= FULL_PCT) begin
			res = FULL_PCT;
		end else if (r <= KNEE_RAW_PCT) begin
			res = 7'(p_lo >> RECIP_SHIFT);
		end else begin
			res = KNEE_SHOWN_PCT + 7'(p_hi >> RECIP_SHIFT);
		end
		return res;
	endfunction

endpackage

/* hw/rtl/bldf_power.sv */
module bldf_power (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [31:0]                now_ms,
	input  logic [6:0]                 raw_clamped,
	input  logic signed [15:0]         cur_ma,
	input  bldf_pkg::cfg_t             cfg,
	output bldf_pkg::pwr_status_t      status
);
	import bldf_pkg::*;

	logic        started_q, started_n;
	logic        mains_q, mains_n;
	logic        pend_q, pend_n;
	logic [31:0] since_q, since_n;
	logic [31:0] freeze_q, freeze_n;
	logic        miss_q, miss_n;
	logic        miss_pend_q, miss_pend_n;
	logic [31:0] miss_since_q, miss_since_n;
	logic        mains_det;
	logic        miss_raw;
	logic [31:0] freeze_diff;

	// Debounce of the mains state, with the freeze restarted on every change.
	always_comb begin
		mains_det = cur_ma <= cfg.mains_thr;
		started_n = started_q;
		mains_n   = mains_q;
		pend_n    = pend_q;
		since_n   = since_q;
		freeze_n  = freeze_q;
		if (!started_q) begin
			mains_n   = mains_det;
			pend_n    = mains_det;
			since_n   = now_ms;
			freeze_n  = now_ms + cfg.freeze;
			started_n = 1'b1;
		end else if (mains_det != mains_q) begin
			if (mains_det != pend_q) begin
				pend_n  = mains_det;
				since_n = now_ms;
			end else if (now_ms - since_q >= cfg.power_deb) begin
				mains_n  = pend_q;
				freeze_n = now_ms + cfg.freeze;
			end
		end else begin
			pend_n  = mains_det;
			since_n = now_ms;
		end
	end

	// Debounce of the battery-missing state; a zero timestamp means not yet seen.
	always_comb begin
		miss_raw = mains_n && (raw_clamped <= MISSING_RAW_PCT)
			&& (cur_ma >= -MISSING_CURRENT_MA) && (cur_ma <= MISSING_CURRENT_MA);
		miss_n       = miss_q;
		miss_pend_n  = miss_pend_q;
		miss_since_n = miss_since_q;
		if (miss_since_q == 32'd0) begin
			miss_n       = miss_raw;
			miss_pend_n  = miss_raw;
			miss_since_n = now_ms;
		end else if (miss_raw != miss_pend_q) begin
			miss_pend_n  = miss_raw;
			miss_since_n = now_ms;
		end else if (miss_pend_q != miss_q
				&& now_ms - miss_since_q >= cfg.missing_deb) begin
			miss_n = miss_pend_q;
		end
	end

	assign freeze_diff        = now_ms - freeze_n;
	assign status.mains_on    = mains_n;
	assign status.batt_absent = miss_n;
	assign status.frozen      = freeze_diff[31];

	// State is committed when the sample leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			mains_q      <= 1'b0;
			pend_q       <= 1'b0;
			since_q      <= '0;
			freeze_q     <= '0;
			miss_q       <= 1'b0;
			miss_pend_q  <= 1'b0;
			miss_since_q <= '0;
		end else if (step) begin
			started_q    <= started_n;
			mains_q      <= mains_n;
			pend_q       <= pend_n;
			since_q      <= since_n;
			freeze_q     <= freeze_n;
			miss_q       <= miss_n;
			miss_pend_q  <= miss_pend_n;
			miss_since_q <= miss_since_n;
		end
	end

endmodule

/* hw/rtl/bldf_level.sv */
module bldf_level (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [31:0]                now_ms,
	input  logic signed [8:0]          gauge_pct,
	input  logic                       charging_now,
	input  bldf_pkg::pwr_status_t      status,
	input  bldf_pkg::cfg_t             cfg,
	output logic [6:0]                 raw_clamped,
	output logic                       disp_valid,
	output logic signed [7:0]          disp_pct,
	output logic signed [7:0]          gauge_out_pct
);
	import bldf_pkg::*;

	logic        shown_started_q, shown_started_n;
	logic [6:0]  shown_q, shown_n;
	logic [31:0] last_adj_q, last_adj_n;
	logic        chg_prev_q;
	logic        raw_ok;
	logic [31:0] elapsed;
	logic [31:0] rise_step;
	logic [6:0]  mapped;

	// Raw level range check and clamp.
	always_comb begin
		raw_ok = (gauge_pct >= 9'sd0) && (gauge_pct <= 9'sd100);
		if (raw_ok) begin
			raw_clamped = gauge_pct[6:0];
		end else if (gauge_pct < 9'sd0) begin
			raw_clamped = 7'd0;
		end else begin
			raw_clamped = FULL_PCT;
		end
		gauge_out_pct = raw_ok ? {1'b0, raw_clamped} : LEVEL_NONE;
	end

	// Rate-limited tracking of the raw level, one percent per step time.
	always_comb begin
		elapsed         = now_ms - last_adj_q;
		rise_step       = status.mains_on ? cfg.rise_mains : cfg.rise_bat;
		shown_started_n = shown_started_q;
		shown_n         = shown_q;
		last_adj_n      = last_adj_q;
		if (!shown_started_q && raw_ok) begin
			shown_n         = raw_clamped;
			shown_started_n = 1'b1;
			last_adj_n      = now_ms;
		end else if (shown_started_q && raw_ok && !status.batt_absent
				&& !status.frozen) begin
			if (raw_clamped < shown_q) begin
				if (!status.mains_on && elapsed >= cfg.drop_step) begin
					shown_n    = shown_q - 7'd1;
					last_adj_n = now_ms;
				end
			end else if (raw_clamped > shown_q) begin
				if (elapsed >= rise_step) begin
					shown_n    = shown_q + 7'd1;
					last_adj_n = now_ms;
				end
			end
		end
	end

	// Display mapping, with a one percent floor while charging on mains.
	always_comb begin
		mapped     = map_usable(shown_n);
		disp_valid = shown_started_n && !status.batt_absent;
		if (!disp_valid) begin
			disp_pct = LEVEL_NONE;
		end else if (status.mains_on && chg_prev_q && shown_n > RESERVE_FLOOR_PCT
				&& mapped == 7'd0) begin
			disp_pct = CHARGING_MIN_PCT;
		end else begin
			disp_pct = {1'b0, mapped};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_started_q <= 1'b0;
			shown_q         <= '0;
			last_adj_q      <= '0;
			chg_prev_q      <= 1'b0;
		end else if (step) begin
			shown_started_q <= shown_started_n;
			shown_q         <= shown_n;
			last_adj_q      <= last_adj_n;
			chg_prev_q      <= charging_now;
		end
	end

endmodule

/* hw/rtl/battery_level_display_filter_unit.sv */
// Battery level display filter.
// One power sample enters per beat on the s_ stream; exactly one result beat
// leaves on the m_ stream for every sample, in order. Settings are written
// through the cfg_ channel (cfg_index selects the register, cfg_data carries
// the value, low 16 bits for the signed current threshold); cfg_ready is
// always high and writes to unused indexes are dropped. Write settings only
// while no sample is in flight.
// An accepted input beat is held in the input register, then the debounce,
// tracking and mapping logic feeds the result register that drives m_tdata.
// Throughput is one sample per cycle while m_tready is high, set by
// the single pass from input register to result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more sample; s_tready drops only when both are full
// and m_tready is low.
// Reset clears all tracking state and loads the default settings: the first
// sample after reset sets the power state directly and starts the freeze.
module battery_level_display_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// now_ms[31:0], gauge_pct[40:32], battery_voltage_mv[55:41],
	// battery_current_ma[71:56], bus_voltage_mv[87:72], charging_now[88], zero fill
	input  logic [bldf_pkg::InDataW-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// mains_on[0], batt_absent[1], disp_valid[2], disp_pct[10:3],
	// gauge_out_pct[18:11], voltage_out_mv[33:19], current_out_ma[49:34],
	// bus_out_mv[65:50], has_bus[66], charging_out[67], zero fill
	output logic [bldf_pkg::OutDataW-1:0]        m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bldf_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [bldf_pkg::CfgDataW-1:0]        cfg_data
);
	import bldf_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	sample_t     sample_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic        advance;
	pwr_status_t status;
	logic [6:0]  raw_clamped;
	logic        disp_valid;
	logic signed [7:0] disp_pct;
	logic signed [7:0] gauge_out_pct;
	result_t     result_n;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mains_thr   <= 16'sd50;
			cfg_q.power_deb   <= 32'd1200;
			cfg_q.missing_deb <= 32'd3000;
			cfg_q.freeze      <= 32'd10000;
			cfg_q.drop_step   <= 32'd120000;
			cfg_q.rise_bat    <= 32'd300000;
			cfg_q.rise_mains  <= 32'd20000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAINS_THR:   cfg_q.mains_thr   <= cfg_data[15:0];
				REG_POWER_DEB:   cfg_q.power_deb   <= cfg_data;
				REG_MISSING_DEB: cfg_q.missing_deb <= cfg_data;
				REG_FREEZE:      cfg_q.freeze      <= cfg_data;
				REG_DROP_STEP:   cfg_q.drop_step   <= cfg_data;
				REG_RISE_BAT:    cfg_q.rise_bat    <= cfg_data;
				REG_RISE_MAINS:  cfg_q.rise_mains  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, result_s2};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[$bits(sample_t)-1:0];
		end
	end

	bldf_power u_power (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.now_ms      (sample_s1.now_ms),
		.raw_clamped (raw_clamped),
		.cur_ma      (sample_s1.battery_current_ma),
		.cfg         (cfg_q),
		.status      (status)
	);

	bldf_level u_level (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.now_ms        (sample_s1.now_ms),
		.gauge_pct     (sample_s1.gauge_pct),
		.charging_now  (sample_s1.charging_now),
		.status        (status),
		.cfg           (cfg_q),
		.raw_clamped   (raw_clamped),
		.disp_valid    (disp_valid),
		.disp_pct      (disp_pct),
		.gauge_out_pct (gauge_out_pct)
	);

	// Result assembly with telemetry passed through.
	always_comb begin
		result_n.mains_on       = status.mains_on;
		result_n.batt_absent    = status.batt_absent;
		result_n.disp_valid     = disp_valid;
		result_n.disp_pct       = disp_pct;
		result_n.gauge_out_pct  = gauge_out_pct;
		result_n.voltage_out_mv = sample_s1.battery_voltage_mv;
		result_n.current_out_ma = sample_s1.battery_current_ma;
		result_n.bus_out_mv     = sample_s1.bus_voltage_mv;
		result_n.has_bus        = !sample_s1.bus_voltage_mv[15];
		result_n.charging_out   = sample_s1.charging_now;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_n;
		end
	end

	// A sample that leaves the input stage always lands in the result register.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("sample lost between input and result register");

	// Input is refused only when both stages are full and the receiver stalls.
	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input refused without a stall");

	// No displayed level while it is flagged invalid.
	a_invalid_level: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.disp_valid) |-> (result_s2.disp_pct == LEVEL_NONE))
		else $error("level shown while not valid");

	// A missing battery never comes with a valid level.
	a_missing_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.batt_absent) |-> !result_s2.disp_valid)
		else $error("valid level with battery missing");

	// A valid level lies within the percent range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.disp_valid)
			|-> (result_s2.disp_pct >= 8'sd0 && result_s2.disp_pct <= 8'sd100))
		else $error("level out of range");

endmodule
